// ===== rtl/srctok_pkg.sv =====
`default_nettype none

package srctok_pkg;

  // default sizes of the scanner
  localparam int KEYWORD_MAX_LEN_DEFAULT = 9;
  localparam int LENGTH_MAX_DEFAULT      = 255;

  // keyword table geometry
  localparam int KW_COUNT    = 19;
  localparam int KW_TEXT_LEN = 9;

  // token kinds
  localparam logic [5:0] K_EOI     = 6'd0;
  localparam logic [5:0] K_IDENT   = 6'd1;
  localparam logic [5:0] K_INT     = 6'd2;
  localparam logic [5:0] K_KW0     = 6'd3;
  localparam logic [5:0] K_PLUS    = 6'd22;
  localparam logic [5:0] K_MINUS   = 6'd23;
  localparam logic [5:0] K_STAR    = 6'd24;
  localparam logic [5:0] K_SLASH   = 6'd25;
  localparam logic [5:0] K_LPAREN  = 6'd26;
  localparam logic [5:0] K_RPAREN  = 6'd27;
  localparam logic [5:0] K_COMMA   = 6'd28;
  localparam logic [5:0] K_SEMI    = 6'd29;
  localparam logic [5:0] K_DOT     = 6'd30;
  localparam logic [5:0] K_HASH    = 6'd31;
  localparam logic [5:0] K_COLON   = 6'd32;
  localparam logic [5:0] K_ASSIGN  = 6'd33;
  localparam logic [5:0] K_LESS    = 6'd34;
  localparam logic [5:0] K_LESS_EQ = 6'd35;
  localparam logic [5:0] K_ERROR   = 6'd36;

  localparam logic [23:0] LINE_MAX_COUNT = 24'hFFFFFF;

  typedef struct packed {
    logic [5:0]  kind;
    logic [7:0]  length;
    logic [23:0] line;
    logic        last;
  } token_t;

  // tokens produced by one scan step, first is sent first
  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } scan_out_t;

  // keyword text, left aligned and padded with spaces, first character in the top byte
  localparam logic [8*KW_TEXT_LEN-1:0] KW_TEXT [KW_COUNT] = '{
    "ARRAY    ", "BEGIN    ", "CONST    ", "DO       ", "IF       ",
    "IMPORT   ", "ELSE     ", "ELSIF    ", "END      ", "MOD      ",
    "MODULE   ", "OF       ", "PROCEDURE", "RETURN   ", "THEN     ",
    "TYPE     ", "VAR      ", "WHILE    ", "WITH     "
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd5, 4'd5, 4'd5, 4'd2, 4'd2, 4'd6, 4'd4, 4'd5, 4'd3, 4'd3,
    4'd6, 4'd2, 4'd9, 4'd6, 4'd4, 4'd4, 4'd3, 4'd5, 4'd4
  };

  // kind of a one-character operator, error for anything unknown
  function automatic logic [5:0] op_kind(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      "+":     k = K_PLUS;
      "-":     k = K_MINUS;
      "*":     k = K_STAR;
      "/":     k = K_SLASH;
      "(":     k = K_LPAREN;
      ")":     k = K_RPAREN;
      ",":     k = K_COMMA;
      ";":     k = K_SEMI;
      ".":     k = K_DOT;
      "#":     k = K_HASH;
      default: k = K_ERROR;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/source_tokenizer.sv =====
// source_tokenizer: lexical scanner, one source byte per input beat
// s side: a beat carries one character in s_tdata, or an end-of-input mark
//   when s_tuser is high (s_tdata is then ignored)
// m side: one token per beat: kind, text length and newline count in m_tdata;
//   m_tlast marks the last token caused by one input beat
// an input beat yields zero, one or two tokens: a character that ends a
//   pending word, number or ':' / '<' first flushes that token, then its own
// path: a taken beat waits in the input register until the scan step runs;
//   the scan step writes its tokens into the queue, whose head m offers
// throughput: one input beat per cycle while m_tready stays high; a beat with
//   two tokens is always followed by one with at most one, so the queue holds
//   no more than two and the output keeps up at one token per cycle
// structure: input register, scan step (state register, keyword compare),
//   four-deep token queue; the scan step runs only with room for two tokens
// stall: while m_tready is low the queue fills, then the scan step holds
//   the input register and s_tready drops; nothing is lost or repeated
// reset: rst clears the scanner to idle, zeroes the line count and empties
//   the input register and the queue; no beats are offered after reset
`default_nettype none

module source_tokenizer import srctok_pkg::*; #(
  parameter int KEYWORD_MAX_LEN = KEYWORD_MAX_LEN_DEFAULT,
  parameter int LENGTH_MAX      = LENGTH_MAX_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] ch
  input  wire logic        s_tuser,   // [0] end_mark
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [5:0] tok_kind, [13:6] token_length,
                                      // [37:14] line_count, [39:38] zero
  output logic             m_tlast    // last token of its input beat
);

  // input register
  logic       in_valid;
  logic [7:0] in_ch;
  logic       in_end;

  logic       go;
  logic       room;
  scan_out_t  scan_result;
  token_t     head;

  // a held beat is scanned once the queue can take both of its tokens
  assign go       = in_valid && room;
  assign s_tready = !in_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_ch  <= s_tdata;
      in_end <= s_tuser;
    end
  end

  srctok_scan #(
    .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN),
    .LENGTH_MAX      (LENGTH_MAX)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .go       (go),
    .ch       (in_ch),
    .end_mark (in_end),
    .result   (scan_result)
  );

  srctok_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (go),
    .wdata      (scan_result),
    .pop        (m_tready),
    .head       (head),
    .head_valid (m_tvalid),
    .room       (room)
  );

  assign m_tdata = {2'b00, head.line, head.length, head.kind};
  assign m_tlast = head.last;

endmodule

`default_nettype wire

// ===== rtl/srctok_scan.sv =====
`default_nettype none

module srctok_scan import srctok_pkg::*; #(
  parameter int KEYWORD_MAX_LEN = KEYWORD_MAX_LEN_DEFAULT,
  parameter int LENGTH_MAX      = LENGTH_MAX_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       go,
  input  wire logic [7:0] ch,
  input  wire logic       end_mark,
  output scan_out_t       result
);

  localparam int RLW = $clog2(LENGTH_MAX + 1);
  localparam int KIW = $clog2(KEYWORD_MAX_LEN);

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_LETTERS = 3'd1;
  localparam logic [2:0] MODE_DIGITS  = 3'd2;
  localparam logic [2:0] MODE_COLON   = 3'd3;
  localparam logic [2:0] MODE_LESS    = 3'd4;

  logic [2:0]     scan_mode, scan_mode_next;
  logic [RLW-1:0] run_length, run_length_next;
  logic [23:0]    line_counter, line_counter_next;
  logic [7:0]     word_buffer [KEYWORD_MAX_LEN];

  logic           buf_we;
  logic [KIW-1:0] buf_idx;

  logic [RLW+7:0] run_ext;
  logic [7:0]     run_len8;
  logic [5:0]     kw_kind;
  logic           ch_alpha, ch_num, is_space;
  logic           flush_en, own_valid;
  logic [5:0]     flush_kind, own_kind;
  logic [7:0]     flush_len, own_len;
  logic [RLW-1:0] run_inc;
  token_t         flush_tok, own_tok;

  assign run_ext  = {8'b0, run_length};
  assign run_len8 = run_ext[7:0];
  assign run_inc  = (int'(run_length) < LENGTH_MAX) ? run_length + RLW'(1) : run_length;

  assign ch_alpha = ch inside {[8'h61:8'h7A], [8'h41:8'h5A]};
  assign ch_num   = ch inside {[8'h30:8'h39]};
  assign is_space = ch inside {8'h20, [8'h09:8'h0D]};

  // parallel compare of the buffered run against every keyword
  always_comb begin
    logic hit;
    kw_kind = K_IDENT;
    for (int i = 0; i < KW_COUNT; i++) begin
      hit = (run_length == RLW'(KW_LEN[i]));
      for (int j = 0; j < KW_TEXT_LEN; j++) begin
        if (j < int'(KW_LEN[i]) && word_buffer[j] != KW_TEXT[i][8*(KW_TEXT_LEN-1-j) +: 8]) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        kw_kind = K_KW0 + 6'(i);
      end
    end
    if (int'(run_length) > KEYWORD_MAX_LEN) begin
      kw_kind = K_IDENT;
    end
  end

  // token for whatever is pending
  always_comb begin
    case (scan_mode)
      MODE_LETTERS: begin
        flush_kind = kw_kind;
        flush_len  = run_len8;
      end
      MODE_DIGITS: begin
        flush_kind = K_INT;
        flush_len  = run_len8;
      end
      MODE_COLON: begin
        flush_kind = K_COLON;
        flush_len  = 8'd1;
      end
      MODE_LESS: begin
        flush_kind = K_LESS;
        flush_len  = 8'd1;
      end
      default: begin
        flush_kind = K_EOI;
        flush_len  = 8'd0;
      end
    endcase
  end

  always_comb begin
    scan_mode_next    = scan_mode;
    run_length_next   = run_length;
    line_counter_next = line_counter;
    buf_we            = 1'b0;
    buf_idx           = run_length[KIW-1:0];
    flush_en          = 1'b0;
    own_valid         = 1'b0;
    own_kind          = K_EOI;
    own_len           = 8'd0;
    if (end_mark) begin
      flush_en       = (scan_mode != MODE_IDLE);
      own_valid      = 1'b1;
      scan_mode_next = MODE_IDLE;
    end else if ((scan_mode == MODE_LETTERS && ch_alpha) ||
                 (scan_mode == MODE_DIGITS && ch_num)) begin
      buf_we          = (int'(run_length) < KEYWORD_MAX_LEN);
      run_length_next = run_inc;
    end else if ((scan_mode == MODE_COLON || scan_mode == MODE_LESS) && ch == "=") begin
      own_valid      = 1'b1;
      own_kind       = (scan_mode == MODE_COLON) ? K_ASSIGN : K_LESS_EQ;
      own_len        = 8'd2;
      scan_mode_next = MODE_IDLE;
    end else begin
      flush_en       = (scan_mode != MODE_IDLE);
      scan_mode_next = MODE_IDLE;
      if (is_space) begin
        if (ch == 8'h0A && line_counter < LINE_MAX_COUNT) begin
          line_counter_next = line_counter + 24'd1;
        end
      end else if (ch_alpha || ch_num) begin
        buf_we          = 1'b1;
        buf_idx         = '0;
        run_length_next = RLW'(1);
        scan_mode_next  = ch_alpha ? MODE_LETTERS : MODE_DIGITS;
      end else if (ch == ":") begin
        scan_mode_next = MODE_COLON;
      end else if (ch == "<") begin
        scan_mode_next = MODE_LESS;
      end else begin
        own_valid = 1'b1;
        own_kind  = op_kind(ch);
        own_len   = 8'd1;
      end
    end
  end

  always_comb begin
    flush_tok.kind   = flush_kind;
    flush_tok.length = flush_len;
    flush_tok.line   = line_counter;
    flush_tok.last   = !own_valid;
    own_tok.kind     = own_kind;
    own_tok.length   = own_len;
    own_tok.line     = line_counter;
    own_tok.last     = 1'b1;
    result.count     = {1'b0, flush_en} + {1'b0, own_valid};
    result.first     = flush_en ? flush_tok : own_tok;
    result.second    = own_tok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode    <= MODE_IDLE;
      run_length   <= '0;
      line_counter <= '0;
    end else if (go) begin
      scan_mode    <= scan_mode_next;
      run_length   <= run_length_next;
      line_counter <= line_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go && buf_we) begin
      word_buffer[buf_idx] <= ch;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/srctok_queue.sv =====
`default_nettype none

module srctok_queue import srctok_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire scan_out_t wdata,
  input  wire logic      pop,
  output token_t         head,
  output logic           head_valid,
  output logic           room
);

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  token_t          mem [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [PW:0]     count;
  logic [1:0]      n_push;
  logic            do_pop;

  assign n_push     = push ? wdata.count : 2'd0;
  assign do_pop     = pop && head_valid;
  assign head       = mem[rd_ptr];
  assign head_valid = (count != '0);
  // room for a full step of two tokens
  assign room       = (count <= (PW+1)'(DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(n_push);
      if (do_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + (PW+1)'(n_push) - (PW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem[wr_ptr] <= wdata.first;
    end
    if (n_push == 2'd2) begin
      mem[wr_ptr + PW'(1)] <= wdata.second;
    end
  end

endmodule

`default_nettype wire

// ===== verif/token_scoreboard_pkg.sv =====
`timescale 1ns / 1ps

package token_scoreboard_pkg;
  import srctok_pkg::*;

  // character codes the scanner cares about
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_VT      = 8'h0B;
  localparam logic [7:0] CH_FF      = 8'h0C;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_LESS    = 8'h3C;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_WORD,
    SCAN_NUMBER,
    SCAN_COLON,
    SCAN_LESS
  } scan_state_e;

  class token_scoreboard;
    scan_state_e state;
    logic [7:0]  word [KEYWORD_MAX_LEN_DEFAULT];
    int unsigned run_len;
    logic [23:0] lines;
    string       keyword_names [KW_COUNT];
    token_t      upcoming [$];
    token_t      beat_tokens [$];
    int unsigned errors;

    function new();
      state = SCAN_IDLE;
      run_len = 0;
      lines = '0;
      errors = 0;
      keyword_names = '{"ARRAY", "BEGIN", "CONST", "DO", "IF", "IMPORT", "ELSE", "ELSIF",
                        "END", "MOD", "MODULE", "OF", "PROCEDURE", "RETURN", "THEN", "TYPE",
                        "VAR", "WHILE", "WITH"};
    endfunction

    function bit alpha_char(logic [7:0] c);
      return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
    endfunction

    function bit num_char(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function void emit(logic [5:0] kind, int unsigned len);
      token_t t;
      t.kind = kind;
      t.length = len[7:0];
      t.line = lines;
      t.last = 1'b0;
      beat_tokens.push_back(t);
    endfunction

    function void add_char(logic [7:0] c);
      if (run_len < KEYWORD_MAX_LEN_DEFAULT) word[run_len] = c;
      if (run_len < LENGTH_MAX_DEFAULT) run_len++;
    endfunction

    // emit whatever token is pending and go back to idle
    function void flush_run();
      logic [5:0] kind;
      string      name;
      bit         hit;
      int         k;
      int         j;
      case (state)
        SCAN_WORD: begin
          kind = K_IDENT;
          if (run_len <= KEYWORD_MAX_LEN_DEFAULT) begin
            for (k = 0; k < KW_COUNT; k++) begin
              name = keyword_names[k];
              if (name.len() == run_len && kind == K_IDENT) begin
                hit = 1'b1;
                for (j = 0; j < run_len; j++)
                  if (name[j] != word[j]) hit = 1'b0;
                if (hit) kind = K_KW0 + 6'(k);
              end
            end
          end
          emit(kind, run_len);
        end
        SCAN_NUMBER: emit(K_INT, run_len);
        SCAN_COLON:  emit(K_COLON, 1);
        SCAN_LESS:   emit(K_LESS, 1);
        default: ;
      endcase
      state = SCAN_IDLE;
    endfunction

    // one accepted input beat: work out the tokens it causes
    function void note_beat(logic [7:0] c, logic eoi);
      token_t t;
      int     i;
      beat_tokens.delete();
      if (eoi) begin
        flush_run();
        emit(K_EOI, 0);
      end else if (state == SCAN_WORD && alpha_char(c)) begin
        add_char(c);
      end else if (state == SCAN_NUMBER && num_char(c)) begin
        add_char(c);
      end else if ((state == SCAN_COLON || state == SCAN_LESS) && c == CH_EQUAL) begin
        emit(state == SCAN_COLON ? K_ASSIGN : K_LESS_EQ, 2);
        state = SCAN_IDLE;
      end else begin
        flush_run();
        if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT || c == CH_FF ||
            c == CH_CR) begin
          if (c == CH_LF && lines != LINE_MAX_COUNT) lines++;
        end else if (alpha_char(c)) begin
          run_len = 0;
          add_char(c);
          state = SCAN_WORD;
        end else if (num_char(c)) begin
          run_len = 0;
          add_char(c);
          state = SCAN_NUMBER;
        end else if (c == CH_COLON) begin
          state = SCAN_COLON;
        end else if (c == CH_LESS) begin
          state = SCAN_LESS;
        end else begin
          case (c)
            "+":     emit(K_PLUS, 1);
            "-":     emit(K_MINUS, 1);
            "*":     emit(K_STAR, 1);
            "/":     emit(K_SLASH, 1);
            "(":     emit(K_LPAREN, 1);
            ")":     emit(K_RPAREN, 1);
            ",":     emit(K_COMMA, 1);
            ";":     emit(K_SEMI, 1);
            ".":     emit(K_DOT, 1);
            "#":     emit(K_HASH, 1);
            default: emit(K_ERROR, 1);
          endcase
        end
      end
      for (i = 0; i < beat_tokens.size(); i++) begin
        t = beat_tokens[i];
        t.last = (i == beat_tokens.size() - 1);
        upcoming.push_back(t);
      end
    endfunction

    function void check_field(string field, logic [23:0] want, logic [23:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    // one output beat against the oldest expected token
    function void check_token(logic [39:0] data, logic last);
      token_t want;
      if (upcoming.size() == 0) begin
        $display("%0t: unexpected token, expected none actual kind %0d length %0d line %0d",
                 $time, data[5:0], data[13:6], data[37:14]);
        errors++;
        return;
      end
      want = upcoming.pop_front();
      check_field("tok_kind", 24'(want.kind), 24'(data[5:0]));
      check_field("token_length", 24'(want.length), 24'(data[13:6]));
      check_field("line_count", want.line, data[37:14]);
      check_field("pad bits", 24'd0, 24'(data[39:38]));
      check_field("last", 24'(want.last), 24'(last));
    endfunction
  endclass

endpackage

// ===== verif/tb_source_tokenizer.sv =====
`timescale 1ns / 1ps

module tb_source_tokenizer;
  import srctok_pkg::*;
  import token_scoreboard_pkg::*;

  // random stimulus stops once at least this many input beats went in, then a final end mark
  localparam int TOTAL_BEATS  = 830;
  // generous bound: ~850 beats, worst gaps and stalls stay far below it
  localparam int CYCLE_LIMIT  = 200000;
  // settle time after the last expected token has been checked
  localparam int DRAIN_CYCLES = 20;

  // operator characters, first one in the top byte
  localparam logic [8*12-1:0] OP_CHARS = "+-*/(),;.#:<";
  localparam logic [47:0] SPACE_CHARS = {CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_VT, CH_FF};

  // receiver stall patterns
  typedef enum logic [1:0] {
    RX_OPEN,     // always ready
    RX_COIN,     // random stalls, one cycle in four
    RX_TRICKLE,  // ready while rx_cycle[2:0] is below 3
    RX_HOLD      // stalled while rx_cycle[5:3] is zero
  } rx_style_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;   // [5:0] tok_kind, [13:6] token_length, [37:14] line_count, [39:38] zero
  logic        m_tlast;

  token_scoreboard sb = new();

  int unsigned cycle_count = 0;
  int unsigned beats_sent = 0;
  int unsigned burst_left = 0;
  logic [15:0] rx_cycle = '0;
  rx_style_e   rx_style = RX_OPEN;

  source_tokenizer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL source_tokenizer");
      $finish;
    end
  end

  // receiver: a new stall style is drawn whenever rx_cycle[7:0] is zero
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1'b1;
    if (rx_cycle[7:0] == 8'd0) rx_style <= rx_style_e'($urandom_range(0, 3));
    case (rx_style)
      RX_OPEN:    m_tready <= 1'b1;
      RX_COIN:    m_tready <= ($urandom_range(0, 3) != 0);
      RX_TRICKLE: m_tready <= (rx_cycle[2:0] < 3'd3);
      default:    m_tready <= (rx_cycle[5:3] != 3'd0);
    endcase
  end

  // monitor: values seen here are the ones from before the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_beat(s_tdata, s_tuser);
      if (m_tvalid && m_tready) sb.check_token(m_tdata, m_tlast);
    end
  end

  // one input beat; returns at the edge where it is taken
  task automatic send_beat(input logic [7:0] c, input logic eoi);
    int unsigned gap;
    if (burst_left == 0) begin
      // end of a burst: drop valid for a random gap, then start a new burst
      s_tvalid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
      // now and then a long stretch with no sender idling
      burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tdata <= c;
    s_tuser <= eoi;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    beats_sent++;
  endtask

  task automatic send_text(input string text);
    int i;
    for (i = 0; i < text.len(); i++) send_beat(text[i], 1'b0);
  endtask

  function automatic logic [7:0] random_letter();
    logic [7:0] base;
    base = $urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A;
    return base + 8'($urandom_range(0, 25));
  endfunction

  // run of letters or digits long enough to saturate the length field
  task automatic send_long_run(input bit digits);
    int n;
    int i;
    n = $urandom_range(256, 270);
    for (i = 0; i < n; i++)
      send_beat(digits ? CH_ZERO + 8'($urandom_range(0, 9)) : random_letter(), 1'b0);
  endtask

  // a keyword, sometimes cut short, miscased or extended so it turns identifier
  task automatic send_keyword();
    string      name;
    int         variant;
    int         n;
    int         i;
    logic [7:0] c;
    name = sb.keyword_names[$urandom_range(0, KW_COUNT - 1)];
    variant = $urandom_range(0, 7);
    n = name.len();
    if (variant == 0 && n > 2) n = n - 1;
    for (i = 0; i < n; i++) begin
      c = name[i];
      if (variant == 1 && i == n - 1) c = c ^ 8'h20;  // flip case of the final letter
      send_beat(c, 1'b0);
    end
    if (variant == 2) send_beat(random_letter(), 1'b0);
  endtask

  task automatic send_random_token();
    int         pick;
    int         n;
    int         i;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      send_keyword();
    end else if (pick < 45) begin
      // identifiers, some longer than any keyword
      n = $urandom_range(1, 12);
      for (i = 0; i < n; i++) send_beat(random_letter(), 1'b0);
    end else if (pick < 55) begin
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++) send_beat(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
    end else if (pick < 70) begin
      // operators; ':' and '<' get an '=' half the time
      c = OP_CHARS[8 * $urandom_range(0, 11) +: 8];
      send_beat(c, 1'b0);
      if ((c == CH_COLON || c == CH_LESS) && $urandom_range(0, 1)) send_beat(CH_EQUAL, 1'b0);
    end else if (pick < 85) begin
      send_beat(SPACE_CHARS[8 * $urandom_range(0, 5) +: 8], 1'b0);
    end else if (pick < 93) begin
      send_beat(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      // end mark with a random, ignored data byte
      send_beat(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  initial begin
    bit long_word_done;
    bit long_number_done;
    long_word_done = 1'b0;
    long_number_done = 1'b0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: keyword ended by ':', ':=', '<' flushed by a letter,
    // newline ending a token, number flushed by an unknown '='
    send_text("IF:=<x\n09=");
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b0);
    send_text(">:");
    // end mark flushing a pending ':', then a second end mark
    send_beat(8'h00, 1'b1);
    send_beat(8'hA5, 1'b1);
    // an identifier, then every one-character operator in a row
    send_text("Az+-*/(),;.#");

    while (beats_sent < TOTAL_BEATS) begin
      if (!long_word_done && beats_sent > 250) begin
        send_long_run(1'b0);
        long_word_done = 1'b1;
      end
      if (!long_number_done && beats_sent > 550) begin
        send_long_run(1'b1);
        long_number_done = 1'b1;
      end
      send_random_token();
    end
    send_beat(8'h00, 1'b1);
    s_tvalid <= 1'b0;

    while (sb.upcoming.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.upcoming.size() == 0) begin
      $display("PASS source_tokenizer");
    end else begin
      $display("FAIL source_tokenizer");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/srctok_pkg.sv
rtl/srctok_scan.sv
rtl/srctok_queue.sv
rtl/source_tokenizer.sv
verif/token_scoreboard_pkg.sv
verif/tb_source_tokenizer.sv
